>>> rtl/tcw_pkg.sv
// Shared types, constants and helpers of the text console writer.
// No dependencies; every other file of the block but tcw_ram imports this package.
package tcw_pkg;

  localparam int unsigned COLUMNS   = 80;
  localparam int unsigned ROWS      = 25;
  localparam int unsigned CELLS     = COLUMNS * ROWS;
  localparam int unsigned ADDR_W    = $clog2(CELLS);
  localparam int unsigned COL_W     = $clog2(COLUMNS);
  localparam int unsigned CUR_RAW_W = $clog2(CELLS + COLUMNS);
  localparam int unsigned CW        = (CUR_RAW_W > 11) ? CUR_RAW_W : 11;

  localparam logic [7:0] NEWLINE_BYTE = 8'd10;
  localparam logic [7:0] NUL_BYTE     = 8'd0;

  typedef enum logic [1:0] {
    OP_READ,
    OP_CHAR,
    OP_NEWLINE,
    OP_SKIP
  } op_kind_e;

  typedef struct packed {
    op_kind_e    kind;
    logic [7:0]  ch;
    logic [10:0] idx;
  } tcw_op_t;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_CLEAR
  } back_state_e;

  // Logical cell to physical RAM address; the screen is a ring of rows starting at top.
  function automatic logic [ADDR_W-1:0] phys_addr(input logic [CW-1:0] cell_no,
                                                  input logic [CW-1:0] top);
    logic [CW:0] sum;
    sum = {1'b0, cell_no} + {1'b0, top};
    if (sum >= (CW+1)'(CELLS)) begin
      sum = sum - (CW+1)'(CELLS);
    end
    return ADDR_W'(sum);
  endfunction

endpackage

>>> rtl/text_console_writer_core.sv
// Top level of the text console writer: front classifier, operation queue and back executor.
// Depends on tcw_pkg, tcw_front, tcw_queue, tcw_back and tcw_ram.
//
// Character-cell console of ROWS x COLUMNS bytes (25 x 80) with a linear cursor. After reset the
// screen store is swept to zero, one cell per cycle over all CELLS = 2000 cells, and no beat
// is taken until the sweep ends. The screen is held as a ring of rows in one single-port RAM,
// so a scroll only moves the top-row pointer and then clears the new bottom row on that port.
// The front takes one beat per cycle into a two-entry queue while the queue is not full. The back
// handles a put, skipped byte or out-of-range read in ST_IDLE and an in-range read in ST_IDLE then
// ST_READ (registered RAM read data); a newline that scrolls the screen clears the row in ST_CLEAR
// after its result, and an ordinary byte written at one past the last cell scrolls it first. One
// result beat leaves per input beat through a registered output.
module text_console_writer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [7:0]  char_in_i,
  input  logic [10:0] cell_index_i,
  input  logic        end_of_write_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [10:0] cursor_pos_o,
  output logic [7:0]  read_char_o,
  output logic        consumed_o
);
  import tcw_pkg::*;

  logic    init_busy;
  logic    q_full, q_push, q_pop, q_valid;
  tcw_op_t push_op, head_op;

  tcw_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .char_in_i     (char_in_i),
    .cell_index_i  (cell_index_i),
    .end_of_write_i(end_of_write_i),
    .init_busy_i   (init_busy),
    .q_full_i      (q_full),
    .push_o        (q_push),
    .op_o          (push_op)
  );

  tcw_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .op_i   (push_op),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .op_o   (head_op)
  );

  tcw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (q_valid),
    .op_i        (head_op),
    .op_pop_o    (q_pop),
    .init_busy_o (init_busy),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cursor_pos_o(cursor_pos_o),
    .read_char_o (read_char_o),
    .consumed_o  (consumed_o)
  );

  a_no_beat_during_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_busy |-> !in_ready_o)
    else $error("input beat offered ready during reset sweep");

  a_pop_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_put_reads_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && consumed_o |-> read_char_o == 8'd0)
    else $error("taken put byte carries read data");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !q_push)
    else $error("queue pushed while full");

endmodule

>>> rtl/tcw_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module tcw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/tcw_front.sv
// Input side: accepts beats, tracks the stop-until-end-of-write flag and classifies each beat.
// Depends on tcw_pkg.
module tcw_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             mode_i,
  input  logic [7:0]       char_in_i,
  input  logic [10:0]      cell_index_i,
  input  logic             end_of_write_i,
  input  logic             init_busy_i,
  input  logic             q_full_i,
  output logic             push_o,
  output tcw_pkg::tcw_op_t op_o
);
  import tcw_pkg::*;

  logic stopped_q, stopped_d;

  assign in_ready_o = !q_full_i && !init_busy_i;
  assign push_o     = in_valid_i && in_ready_o;

  always_comb begin
    stopped_d = stopped_q;
    op_o.ch   = char_in_i;
    op_o.idx  = cell_index_i;
    op_o.kind = OP_SKIP;
    if (mode_i) begin
      op_o.kind = OP_READ;
    end else begin
      if (!stopped_q) begin
        if (char_in_i == NUL_BYTE) begin
          op_o.kind = OP_SKIP;
          stopped_d = 1'b1;
        end else if (char_in_i == NEWLINE_BYTE) begin
          op_o.kind = OP_NEWLINE;
        end else begin
          op_o.kind = OP_CHAR;
        end
      end
      if (end_of_write_i) begin
        stopped_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stopped_q <= 1'b0;
    end else if (push_o) begin
      stopped_q <= stopped_d;
    end
  end

endmodule

>>> rtl/tcw_queue.sv
// Two-entry queue of classified operations between the front and back parts.
// Depends on tcw_pkg.
module tcw_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  tcw_pkg::tcw_op_t op_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output tcw_pkg::tcw_op_t op_o
);
  import tcw_pkg::*;

  tcw_op_t    slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign op_o    = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

>>> rtl/tcw_back.sv
// Execution side: cursor, ring-of-rows screen store, row clearing and the result register.
// Depends on tcw_pkg and tcw_ram.
module tcw_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             op_valid_i,
  input  tcw_pkg::tcw_op_t op_i,
  output logic             op_pop_o,
  output logic             init_busy_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [10:0]      cursor_pos_o,
  output logic [7:0]       read_char_o,
  output logic             consumed_o
);
  import tcw_pkg::*;

  back_state_e       state_q, state_d;
  logic [CW-1:0]     cursor_q, cursor_d;
  logic [COL_W-1:0]  ccol_q, ccol_d;
  logic [CW-1:0]     top_q, top_d;
  logic [ADDR_W-1:0] clr_addr_q, clr_addr_d;
  logic [CW-1:0]     clr_left_q, clr_left_d;

  logic              out_valid_q;
  logic [10:0]       out_cursor_q, out_cursor_d;
  logic [7:0]        out_read_q, out_read_d;
  logic              out_cons_q, out_cons_d;
  logic              out_load;
  logic              out_free;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_addr;
  logic [7:0]        ram_wdata, ram_rdata;

  logic [CW-1:0]     nl_cur, top_next;

  tcw_ram #(
    .WIDTH(8),
    .DEPTH(CELLS)
  ) u_screen (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .re_i   (ram_re),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  assign out_free = !out_valid_q || out_ready_i;
  assign nl_cur   = cursor_q + CW'(COLUMNS) - CW'(ccol_q);
  assign top_next = (top_q == CW'(CELLS - COLUMNS)) ? '0 : top_q + CW'(COLUMNS);

  always_comb begin
    state_d      = state_q;
    cursor_d     = cursor_q;
    ccol_d       = ccol_q;
    top_d        = top_q;
    clr_addr_d   = clr_addr_q;
    clr_left_d   = clr_left_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_addr     = '0;
    ram_wdata    = NUL_BYTE;
    op_pop_o     = 1'b0;
    out_load     = 1'b0;
    out_cursor_d = cursor_q[10:0];
    out_read_d   = 8'd0;
    out_cons_d   = 1'b0;

    case (state_q)
      ST_INIT: begin
        ram_we     = 1'b1;
        ram_addr   = clr_addr_q;
        clr_addr_d = clr_addr_q + ADDR_W'(1);
        if (clr_addr_q == ADDR_W'(CELLS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (op_valid_i) begin
          case (op_i.kind)
            OP_READ: begin
              if (CW'(op_i.idx) >= CW'(CELLS)) begin
                if (out_free) begin
                  out_load = 1'b1;
                  op_pop_o = 1'b1;
                end
              end else begin
                ram_re   = 1'b1;
                ram_addr = phys_addr(CW'(op_i.idx), top_q);
                op_pop_o = 1'b1;
                state_d  = ST_READ;
              end
            end
            OP_CHAR: begin
              if (cursor_q == CW'(CELLS)) begin
                // scroll first; the byte is written once the row is clear
                top_d      = top_next;
                cursor_d   = cursor_q - CW'(COLUMNS);
                clr_addr_d = ADDR_W'(top_q);
                clr_left_d = CW'(COLUMNS);
                state_d    = ST_CLEAR;
              end else if (out_free) begin
                ram_we       = 1'b1;
                ram_addr     = phys_addr(cursor_q, top_q);
                ram_wdata    = op_i.ch;
                cursor_d     = cursor_q + CW'(1);
                ccol_d       = (ccol_q == COL_W'(COLUMNS - 1)) ? '0 : ccol_q + COL_W'(1);
                out_load     = 1'b1;
                out_cursor_d = cursor_d[10:0];
                out_cons_d   = 1'b1;
                op_pop_o     = 1'b1;
              end
            end
            OP_NEWLINE: begin
              if (out_free) begin
                ccol_d     = '0;
                out_load   = 1'b1;
                out_cons_d = 1'b1;
                op_pop_o   = 1'b1;
                if (nl_cur > CW'(CELLS - 1)) begin
                  cursor_d   = nl_cur - CW'(COLUMNS);
                  top_d      = top_next;
                  clr_addr_d = ADDR_W'(top_q);
                  clr_left_d = CW'(COLUMNS);
                  state_d    = ST_CLEAR;
                end else begin
                  cursor_d = nl_cur;
                end
                out_cursor_d = cursor_d[10:0];
              end
            end
            default: begin
              if (out_free) begin
                out_load = 1'b1;
                op_pop_o = 1'b1;
              end
            end
          endcase
        end
      end
      ST_READ: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_read_d = ram_rdata;
          state_d    = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        ram_we     = 1'b1;
        ram_addr   = clr_addr_q;
        clr_addr_d = clr_addr_q + ADDR_W'(1);
        clr_left_d = clr_left_q - CW'(1);
        if (clr_left_q == CW'(1)) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      cursor_q    <= '0;
      ccol_q      <= '0;
      top_q       <= '0;
      clr_addr_q  <= '0;
      clr_left_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cursor_q   <= cursor_d;
      ccol_q     <= ccol_d;
      top_q      <= top_d;
      clr_addr_q <= clr_addr_d;
      clr_left_q <= clr_left_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_cursor_q <= out_cursor_d;
      out_read_q   <= out_read_d;
      out_cons_q   <= out_cons_d;
    end
  end

  assign init_busy_o  = (state_q == ST_INIT);
  assign out_valid_o  = out_valid_q;
  assign cursor_pos_o = out_cursor_q;
  assign read_char_o  = out_read_q;
  assign consumed_o   = out_cons_q;

endmodule
